### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/tpsa_pkg.sv
`default_nettype none
package tpsa_pkg;

    localparam int MAP_W    = 64;
    localparam int SLOT_W   = 7;
    localparam int IDX_W    = 6;
    localparam int SIZE_W   = 17;
    localparam int OFFSET_W = 22;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_OBJECT_SLOTS  = 64;
    localparam int DEF_SKINNED_SLOTS = 64;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);
    localparam logic [SIZE_W-1:0] SIZE_SAT   = SIZE_W'(65536);

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_QUERY   = 2'd2
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_POOL_EMPTY   = 2'd1,
        ST_ALREADY_FREE = 2'd2,
        ST_OUT_OF_RANGE = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OBJECT_SIZE  = 2'd0,
        CFG_SKINNED_SIZE = 2'd1
    } t_cfg_idx;

endpackage
`default_nettype wire

### rtl/two_pool_slot_allocator.sv
// Two-pool slot allocator: hands out and takes back numbered slots (1-based)
// of an object pool and a skinned pool, and turns a slot into a byte offset.
// Request channel: i_in_valid / o_in_ready carry one word with i_req_type
// (allocate, release, offset query), i_pool_select and i_slot_in.
// Result channel: o_out_valid / i_out_ready carry one word per request with
// o_status, o_slot_out and o_byte_offset.
// Config channel: i_cfg_valid / o_cfg_ready write entry sizes by index
// (0 object, 1 skinned); other indexes are dropped. Write only while idle.
// Path: an accepted request goes through the input register, then the result
// register, which drives the outputs. Throughput: one request per cycle while
// each result is taken; the free maps update as the word moves into the result
// register, so back-to-back allocates see each other.
// Reset: every slot of both pools free, both entry sizes 256.
// Stall: while the result waits, the input register still takes one word;
// after that o_in_ready drops until the result is taken.
`default_nettype none
`include "assert_macros.svh"
module two_pool_slot_allocator #(
    parameter int OBJECT_SLOTS  = tpsa_pkg::DEF_OBJECT_SLOTS,
    parameter int SKINNED_SLOTS = tpsa_pkg::DEF_SKINNED_SLOTS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [tpsa_pkg::REQ_W-1:0]      i_req_type,
    input  wire logic                            i_pool_select,
    input  wire logic [tpsa_pkg::SLOT_W-1:0]     i_slot_in,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [tpsa_pkg::STATUS_W-1:0]        o_status,
    output logic [tpsa_pkg::SLOT_W-1:0]          o_slot_out,
    output logic [tpsa_pkg::OFFSET_W-1:0]        o_byte_offset,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [tpsa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tpsa_pkg::SIZE_W-1:0]     i_cfg_data
);
    import tpsa_pkg::*;

    // Valid-slot masks and slot counts per pool.
    localparam logic [MAP_W-1:0] OBJ_MASK = {MAP_W{1'b1}} >> (MAP_W - OBJECT_SLOTS);
    localparam logic [MAP_W-1:0] SKN_MASK = {MAP_W{1'b1}} >> (MAP_W - SKINNED_SLOTS);
    localparam logic [SLOT_W-1:0] OBJ_COUNT = SLOT_W'(OBJECT_SLOTS);
    localparam logic [SLOT_W-1:0] SKN_COUNT = SLOT_W'(SKINNED_SLOTS);

    // Entry size registers.
    logic [SIZE_W-1:0] r_obj_size;
    logic [SIZE_W-1:0] r_skn_size;

    // Free maps, bit s-1 set when slot s is free.
    logic [MAP_W-1:0] r_obj_map, n_obj_map;
    logic [MAP_W-1:0] r_skn_map, n_skn_map;

    // Input register.
    logic              r_in_valid;
    t_req              r_req;
    logic              r_pool;
    logic [SLOT_W-1:0] r_slot;

    // Result register.
    logic                r_out_valid;
    t_status             r_status, n_status;
    logic [SLOT_W-1:0]   r_slot_out, n_slot_out;
    logic [OFFSET_W-1:0] r_offset, n_offset;

    logic                advance;
    logic [MAP_W-1:0]    sel_map;
    logic [MAP_W-1:0]    sel_mask;
    logic [MAP_W-1:0]    avail;
    logic [MAP_W-1:0]    new_map;
    logic [SLOT_W-1:0]   sel_count;
    logic [SIZE_W-1:0]   sel_size;
    logic [SIZE_W-1:0]   size_sat;
    logic [IDX_W-1:0]    low_idx;
    logic                found;
    logic                in_range;
    logic [IDX_W-1:0]    slot_m1;
    logic [OFFSET_W-1:0] product;

    // Move the held word into the result register when that is empty or drains.
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_slot_out    = r_slot_out;
    assign o_byte_offset = r_offset;

    // Pick the addressed pool.
    assign sel_map   = r_pool ? r_skn_map  : r_obj_map;
    assign sel_mask  = r_pool ? SKN_MASK   : OBJ_MASK;
    assign sel_count = r_pool ? SKN_COUNT  : OBJ_COUNT;
    assign sel_size  = r_pool ? r_skn_size : r_obj_size;
    assign avail     = sel_map & sel_mask;
    assign found     = |avail;

    // Saturate entry sizes above 64 KiB.
    assign size_sat = sel_size[SIZE_W-1] ? SIZE_SAT : sel_size;

    assign in_range = (r_slot != '0) && (r_slot <= sel_count);
    assign slot_m1  = IDX_W'(r_slot - SLOT_W'(1));
    // At most 63 * 65536, which fits the offset width.
    assign product  = OFFSET_W'(slot_m1) * OFFSET_W'(size_sat);

    // Priority encoder: lowest free slot wins.
    always_comb begin
        low_idx = '0;
        for (int i = MAP_W - 1; i >= 0; i--) begin
            if (avail[i]) begin
                low_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        new_map    = sel_map;
        n_status   = ST_OK;
        n_slot_out = '0;
        n_offset   = '0;
        case (r_req)
            REQ_ALLOC: begin
                if (!found) begin
                    n_status = ST_POOL_EMPTY;
                end else begin
                    new_map[low_idx] = 1'b0;
                    n_slot_out       = SLOT_W'(low_idx) + SLOT_W'(1);
                end
            end
            REQ_RELEASE: begin
                if (!in_range) begin
                    n_status = ST_OUT_OF_RANGE;
                end else if (sel_map[slot_m1]) begin
                    n_status = ST_ALREADY_FREE;
                end else begin
                    new_map[slot_m1] = 1'b1;
                end
            end
            REQ_QUERY: begin
                if (!in_range) begin
                    n_status = ST_OUT_OF_RANGE;
                end else begin
                    n_offset = product;
                end
            end
            default: begin
                // Unused request code: answer ok, change nothing.
            end
        endcase
    end

    always_comb begin
        n_obj_map = r_obj_map;
        n_skn_map = r_skn_map;
        if (advance) begin
            if (r_pool) begin
                n_skn_map = new_map;
            end else begin
                n_obj_map = new_map;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obj_size  <= SIZE_RESET;
            r_skn_size  <= SIZE_RESET;
            r_obj_map   <= OBJ_MASK;
            r_skn_map   <= SKN_MASK;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_obj_map <= n_obj_map;
            r_skn_map <= n_skn_map;
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_OBJECT_SIZE:  r_obj_size <= i_cfg_data;
                    CFG_SKINNED_SIZE: r_skn_size <= i_cfg_data;
                    default: begin
                        // Drop writes to unknown indexes.
                    end
                endcase
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req  <= t_req'(i_req_type);
            r_pool <= i_pool_select;
            r_slot <= i_slot_in;
        end
        if (advance) begin
            r_status   <= n_status;
            r_slot_out <= n_slot_out;
            r_offset   <= n_offset;
        end
    end

    `ASSERT_ALWAYS(a_obj_map_in_pool, (r_obj_map & ~OBJ_MASK) == '0, "object map beyond pool")
    `ASSERT_ALWAYS(a_skn_map_in_pool, (r_skn_map & ~SKN_MASK) == '0, "skinned map beyond pool")
    `ASSERT_IMPLY(a_slot_only_ok, r_out_valid && (r_slot_out != '0), r_status == ST_OK, "slot with error")
    `ASSERT_IMPLY(a_offset_only_ok, r_out_valid && (r_offset != '0), r_status == ST_OK, "offset with error")
    `ASSERT_IMPLY(a_held_blocks, r_in_valid && r_out_valid && !i_out_ready, !o_in_ready, "overrun")

endmodule
`default_nettype wire
